// File: rtl/core/fphit_pkg.sv
package fphit_pkg;

   localparam int MAX_ENTRIES_DEF = 16;
   localparam int NUM_POINTS      = 4;
   localparam int COORD_W         = 16;
   localparam int EDGE_W          = COORD_W + 1;
   localparam int SIZE_W          = 15;
   localparam int INDEX_W         = 4;
   localparam int SLOT_COUNT      = 2 ** INDEX_W;
   localparam int COUNT_W         = 5;
   localparam int REQ_DATA_W      = 136;
   localparam int RSP_DATA_W      = 72;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } point_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] top;
      logic [SIZE_W-1:0]         width;
      logic [SIZE_W-1:0]         height;
   } box_type;

   typedef struct packed {
      logic               hit;
      logic [INDEX_W-1:0] hit_index;
      box_type            box;
   } token_type;

endpackage

// File: rtl/core/fphit_cell.sv
module fphit_cell #(
   parameter int INDEX = 0
) (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic                                                 wr_en_i,
   input  logic [fphit_pkg::INDEX_W-1:0]                        wr_index_i,
   input  fphit_pkg::box_type                                   wr_box_i,
   input  logic [fphit_pkg::COUNT_W-1:0]                        count_i,
   input  fphit_pkg::point_type [fphit_pkg::NUM_POINTS-1:0]     points_i,
   input  logic                                                 valid_i,
   input  fphit_pkg::token_type                                 token_i,
   output logic                                                 valid_o,
   output fphit_pkg::token_type                                 token_o
);

   localparam logic WRITABLE = (INDEX < fphit_pkg::SLOT_COUNT);

   fphit_pkg::box_type                        box_ff;
   logic signed [fphit_pkg::EDGE_W-1:0]       right_ff;
   logic signed [fphit_pkg::EDGE_W-1:0]       bottom_ff;
   logic signed [fphit_pkg::EDGE_W-1:0]       right_in;
   logic signed [fphit_pkg::EDGE_W-1:0]       bottom_in;
   logic                                      sel;
   logic                                      active;
   logic [fphit_pkg::NUM_POINTS-1:0]          pt_hit;
   logic                                      valid_ff;
   fphit_pkg::token_type                      token_ff;
   fphit_pkg::token_type                      token_in;

   assign sel = wr_en_i && WRITABLE &&
                (wr_index_i == fphit_pkg::INDEX_W'(INDEX));

   assign right_in  = {wr_box_i.left[fphit_pkg::COORD_W-1], wr_box_i.left} +
                      $signed({2'b00, wr_box_i.width});
   assign bottom_in = {wr_box_i.top[fphit_pkg::COORD_W-1], wr_box_i.top} +
                      $signed({2'b00, wr_box_i.height});

   always_ff @(posedge clock) begin
      if (sel) begin
         box_ff    <= wr_box_i;
         right_ff  <= right_in;
         bottom_ff <= bottom_in;
      end
   end

   assign active = INDEX < int'(count_i);

   always_comb begin
      for (int p = 0; p < fphit_pkg::NUM_POINTS; p++) begin
         pt_hit[p] = (points_i[p].x >= box_ff.left) &&
                     ($signed({points_i[p].x[fphit_pkg::COORD_W-1], points_i[p].x})
                        <= right_ff) &&
                     (points_i[p].y >= box_ff.top) &&
                     ($signed({points_i[p].y[fphit_pkg::COORD_W-1], points_i[p].y})
                        <= bottom_ff);
      end
   end

   always_comb begin
      token_in = token_i;
      if (!token_i.hit && active && (|pt_hit)) begin
         token_in.hit       = 1'b1;
         token_in.hit_index = fphit_pkg::INDEX_W'(INDEX);
         token_in.box       = box_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      token_ff <= token_in;
   end

   assign valid_o = valid_ff;
   assign token_o = token_ff;

endmodule

// File: rtl/core/four_point_box_hit_test_core.sv
// Box write: the box is stored when the request is accepted; an all-zero response is then
//   loaded in ST_HOLD. Point query: the points are registered on acceptance and the query
//   token walks the row of box cells, one cell per cycle; the token leaving the last cell is the response.
// One request in flight; a new request is taken while a response waits on rsp_tready.
// Reset (synchronous, active high) clears entry_count and all handshake state;
//   box entries are undefined until written.
module four_point_box_hit_test_core #(
   parameter int MAX_ENTRIES = fphit_pkg::MAX_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // entry_index[3:0], px0, py0, px1, py1, px2, py2, px3, py3 (16 each), zero pad
   input  logic [fphit_pkg::REQ_DATA_W-1:0]    req_tdata,
   // opcode
   input  logic                                req_tuser,
   // response
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // hit, hit_index[3:0], hit_left[15:0], hit_top[15:0], hit_width[14:0],
   // hit_height[14:0], zero pad
   output logic [fphit_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // config
   input  logic                                csr_wr_en,
   input  logic [fphit_pkg::COUNT_W-1:0]       csr_wr_data
);

   localparam int CW = fphit_pkg::COORD_W;

   fphit_pkg::state_type                              state_ff, state_in;
   logic [fphit_pkg::COUNT_W-1:0]                     count_ff;
   fphit_pkg::point_type [fphit_pkg::NUM_POINTS-1:0]  points_ff;
   fphit_pkg::point_type [fphit_pkg::NUM_POINTS-1:0]  req_points;
   logic                                              inject_ff, inject_in;
   fphit_pkg::token_type                              res_ff, res_in;
   logic                                              rsp_tvalid_ff, rsp_tvalid_in;
   fphit_pkg::token_type                              rsp_tok_ff;
   logic                                              rsp_load;
   logic                                              accept;
   logic                                              wr_en;
   logic [fphit_pkg::INDEX_W-1:0]                     req_index;
   fphit_pkg::box_type                                wr_box;
   logic signed [CW-1:0]                              req_w;
   logic signed [CW-1:0]                              req_h;

   logic                 chain_valid [MAX_ENTRIES+1];
   fphit_pkg::token_type chain_tok   [MAX_ENTRIES+1];

   assign accept    = req_tvalid && req_tready;
   assign req_index = req_tdata[fphit_pkg::INDEX_W-1:0];

   always_comb begin
      for (int p = 0; p < fphit_pkg::NUM_POINTS; p++) begin
         req_points[p].x = req_tdata[fphit_pkg::INDEX_W + 2*CW*p +: CW];
         req_points[p].y = req_tdata[fphit_pkg::INDEX_W + 2*CW*p + CW +: CW];
      end
   end

   assign wr_en = accept && (fphit_pkg::opcode_type'(req_tuser) == fphit_pkg::OP_WRITE);

   // negative sizes saturate to zero
   assign req_w = req_points[1].x;
   assign req_h = req_points[1].y;
   always_comb begin
      wr_box.left   = req_points[0].x;
      wr_box.top    = req_points[0].y;
      wr_box.width  = req_w[CW-1] ? '0 : req_w[fphit_pkg::SIZE_W-1:0];
      wr_box.height = req_h[CW-1] ? '0 : req_h[fphit_pkg::SIZE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         points_ff <= req_points;
      end
   end

   assign chain_valid[0] = inject_ff;
   assign chain_tok[0]   = '0;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      fphit_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .wr_en_i    (wr_en),
         .wr_index_i (req_index),
         .wr_box_i   (wr_box),
         .count_i    (count_ff),
         .points_i   (points_ff),
         .valid_i    (chain_valid[i]),
         .token_i    (chain_tok[i]),
         .valid_o    (chain_valid[i+1]),
         .token_o    (chain_tok[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fphit_pkg::ST_IDLE;
         inject_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         inject_ff     <= inject_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (rsp_load) begin
         rsp_tok_ff <= res_ff;
      end
   end

   always_comb begin
      state_in   = state_ff;
      inject_in  = 1'b0;
      res_in     = res_ff;
      rsp_load   = 1'b0;
      req_tready = 1'b0;
      case (state_ff)
         fphit_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               if (wr_en) begin
                  res_in   = '0;
                  state_in = fphit_pkg::ST_HOLD;
               end else begin
                  inject_in = 1'b1;
                  state_in  = fphit_pkg::ST_SCAN;
               end
            end
         end
         fphit_pkg::ST_SCAN: begin
            if (chain_valid[MAX_ENTRIES]) begin
               res_in   = chain_tok[MAX_ENTRIES];
               state_in = fphit_pkg::ST_HOLD;
            end
         end
         fphit_pkg::ST_HOLD: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = fphit_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fphit_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid_in = rsp_load || (rsp_tvalid_ff && !rsp_tready);

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {5'b00000,
                        rsp_tok_ff.box.height,
                        rsp_tok_ff.box.width,
                        rsp_tok_ff.box.top,
                        rsp_tok_ff.box.left,
                        rsp_tok_ff.hit_index,
                        rsp_tok_ff.hit};

endmodule
